// ===== rtl/core/smx_pkg.sv =====
// Shared types and constants of the stack machine executor.
package smx_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CntW        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DataW       = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned KindW       = 3;
  localparam logic [DataW-1:0] LowByteMask = 32'h0000_00FF;

  typedef enum logic [OpW-1:0] {
    OpPush  = 3'd0,
    OpAdd   = 3'd1,
    OpSub   = 3'd2,
    OpMul   = 3'd3,
    OpPrint = 3'd4,
    OpHalt  = 3'd5
  } opcode_e;

  typedef enum logic [KindW-1:0] {
    KindArith  = 3'd0,
    KindPrint  = 3'd1,
    KindHalted = 3'd2,
    KindBadOp  = 3'd3,
    KindUnder  = 3'd4,
    KindOver   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CellHold     = 2'd0,
    CellFromUp   = 2'd1,
    CellFromDown = 2'd2
  } cell_cmd_e;

endpackage

// ===== rtl/core/stack_machine_executor_core.sv =====
// Top level of the stack machine executor: a shifting row of stack cells with the top in cell 0.
// The block executes one instruction per clock cycle: the stack is a row of cells that all
// shift together, so push, pop and a binary operation on the two top entries finish in the
// cycle the item is accepted, and a new item can follow in the next cycle. A result appears in
// the output register in the cycle after its item is accepted; the input side keeps accepting as
// long as that register is empty or being drained. The 32-bit multiplier in front of the top
// cell is the longest path.
module stack_machine_executor_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic signed [31:0]       s_axis_tdata,  // [31:0] immediate
  input  logic [2:0]               s_axis_tuser,  // [2:0] op
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic signed [31:0]       m_axis_tdata,  // [31:0] value
  output logic [2:0]               m_axis_tuser   // [2:0] kind
);

  localparam int unsigned Depth = smx_pkg::STACK_DEPTH;
  localparam int unsigned CntW  = smx_pkg::CntW;
  localparam int unsigned DataW = smx_pkg::DataW;

  logic [DataW-1:0]   cell_val [Depth];
  smx_pkg::cell_cmd_e cmd_top, cmd_rest;
  logic [DataW-1:0]   top_in;
  logic [DataW-1:0]   alu_res;

  logic [CntW-1:0]    count_q, count_d;
  logic               stopped_q, stopped_d;
  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_value_q, out_value_d;
  smx_pkg::kind_e     out_kind_q, out_kind_d;

  logic               accept;
  logic               work;
  smx_pkg::opcode_e   op;
  logic [DataW-1:0]   top_val;
  logic [DataW-1:0]   next_val;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign work          = accept && !stopped_q;
  assign op            = smx_pkg::opcode_e'(s_axis_tuser);
  assign top_val       = cell_val[0];
  assign next_val      = cell_val[1];

  smx_alu u_alu (
    .op_i  (op),
    .a_i   (next_val),
    .b_i   (top_val),
    .res_o (alu_res)
  );

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [DataW-1:0] up_v, down_v;
    smx_pkg::cell_cmd_e cmd_v;
    if (g == 0) begin : g_top
      assign up_v  = top_in;
      assign cmd_v = cmd_top;
    end else begin : g_mid
      assign up_v  = cell_val[g-1];
      assign cmd_v = cmd_rest;
    end
    if (g == Depth - 1) begin : g_last
      assign down_v = '0;
    end else begin : g_inner
      assign down_v = cell_val[g+1];
    end
    smx_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_v),
      .up_i   (up_v),
      .down_i (down_v),
      .val_o  (cell_val[g])
    );
  end

  always_comb begin
    cmd_top     = smx_pkg::CellHold;
    cmd_rest    = smx_pkg::CellHold;
    top_in      = alu_res;
    count_d     = count_q;
    stopped_d   = stopped_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_value_d = out_value_q;
    out_kind_d  = out_kind_q;
    if (work) begin
      case (op)
        smx_pkg::OpPush: begin
          if (count_q == CntW'(Depth)) begin
            stopped_d   = 1'b1;
            out_valid_d = 1'b1;
            out_value_d = '0;
            out_kind_d  = smx_pkg::KindOver;
          end else begin
            top_in   = s_axis_tdata;
            cmd_top  = smx_pkg::CellFromUp;
            cmd_rest = smx_pkg::CellFromUp;
            count_d  = count_q + 1'b1;
          end
        end
        smx_pkg::OpAdd, smx_pkg::OpSub, smx_pkg::OpMul: begin
          out_valid_d = 1'b1;
          if (count_q < CntW'(2)) begin
            stopped_d   = 1'b1;
            out_value_d = '0;
            out_kind_d  = smx_pkg::KindUnder;
          end else begin
            cmd_top     = smx_pkg::CellFromUp;
            cmd_rest    = smx_pkg::CellFromDown;
            count_d     = count_q - 1'b1;
            out_value_d = alu_res;
            out_kind_d  = smx_pkg::KindArith;
          end
        end
        smx_pkg::OpPrint, smx_pkg::OpHalt: begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            stopped_d   = 1'b1;
            out_value_d = '0;
            out_kind_d  = smx_pkg::KindUnder;
          end else if (op == smx_pkg::OpHalt) begin
            stopped_d   = 1'b1;
            out_value_d = top_val & smx_pkg::LowByteMask;
            out_kind_d  = smx_pkg::KindHalted;
          end else begin
            out_value_d = top_val;
            out_kind_d  = smx_pkg::KindPrint;
          end
        end
        default: begin
          stopped_d   = 1'b1;
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_kind_d  = smx_pkg::KindBadOp;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_kind_q  <= out_kind_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_kind_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("stack count exceeds depth");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stopped block resumed without reset");

  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == smx_pkg::KindBadOp || out_kind_q == smx_pkg::KindUnder ||
     out_kind_q == smx_pkg::KindOver || out_kind_q == smx_pkg::KindHalted)) |-> stopped_q)
    else $error("error or halt result without stop");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && op == smx_pkg::OpPush && count_q != CntW'(Depth)) |=>
      (count_q == $past(count_q) + 1'b1))
    else $error("push did not grow the stack");

  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stopped_q && !out_valid_q) |=> !out_valid_q)
    else $error("result produced while stopped");

endmodule

// ===== rtl/core/smx_cell.sv =====
// One stack entry cell that loads from its upper or lower neighbor or holds.
module smx_cell (
  input  logic                     clk_i,
  input  smx_pkg::cell_cmd_e       cmd_i,
  input  logic [smx_pkg::DataW-1:0] up_i,
  input  logic [smx_pkg::DataW-1:0] down_i,
  output logic [smx_pkg::DataW-1:0] val_o
);

  logic [smx_pkg::DataW-1:0] val_q, val_d;

  always_comb begin
    case (cmd_i)
      smx_pkg::CellFromUp:   val_d = up_i;
      smx_pkg::CellFromDown: val_d = down_i;
      default:               val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== rtl/core/smx_alu.sv =====
// Wrapping 32-bit add, subtract and multiply of the two top stack entries.
module smx_alu (
  input  smx_pkg::opcode_e          op_i,
  input  logic [smx_pkg::DataW-1:0] a_i,
  input  logic [smx_pkg::DataW-1:0] b_i,
  output logic [smx_pkg::DataW-1:0] res_o
);

  always_comb begin
    case (op_i)
      smx_pkg::OpAdd: res_o = a_i + b_i;
      smx_pkg::OpSub: res_o = a_i - b_i;
      smx_pkg::OpMul: res_o = a_i * b_i;
      default:        res_o = '0;
    endcase
  end

endmodule
